[rtl/core/pip_pkg.sv]
// ----------------------------------------------------------------------------
// pip_pkg - shared types and constants for the point-in-polygon tester
// Fixed coordinate and arithmetic widths, request codes and sequencer states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pip_pkg;

    // coordinate and register widths
    localparam int COORD_W = 32;
    localparam int TOL_W   = 16;

    // differences of two coordinates
    localparam int DIFF_W  = COORD_W + 1;
    // differences involving the tolerance
    localparam int EXT_W   = COORD_W + 2;

    // shared multiplier: full operand times one half of the other
    localparam int HALF_W  = (EXT_W + 1) / 2;
    localparam int MUL_A_W = EXT_W + 1;
    localparam int MUL_B_W = HALF_W + 1;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int ACC_W   = PROD_W + HALF_W;

    // request codes
    localparam logic [1:0] FUNC_CLEAR  = 2'd0;
    localparam logic [1:0] FUNC_APPEND = 2'd1;
    localparam logic [1:0] FUNC_TEST   = 2'd2;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_EDGE1,
        S_EDGE2,
        S_MUL,
        S_ACC,
        S_OUT
    } t_state;

    // partial products of the crossing compare
    typedef enum logic [1:0] {
        MS_DX_LO,
        MS_DX_HI,
        MS_DY_LO,
        MS_DY_HI
    } t_mul_step;

endpackage

[rtl/core/point_in_polygon_ray_cast.sv]
// ----------------------------------------------------------------------------
// point_in_polygon_ray_cast - even-odd point-in-polygon test
// Clear and append take effect at acceptance; a test of an empty polygon
// gives its result in the cycle after acceptance. A test reads vertices
// through one read port and walks each edge through load and edge states;
// edges needing the crossing multiply also use the shared 35x18 multiplier.
// Reset (synchronous, active low) empties the polygon, clears the truncated
// flag and the tolerance; the vertex store itself is not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module point_in_polygon_ray_cast
    import pip_pkg::*;
#(
    parameter int MAX_VERTICES = 64
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,

    // request channel
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [1:0]                i_func,
    input  logic signed [COORD_W-1:0] i_px,
    input  logic signed [COORD_W-1:0] i_py,

    // result channel
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic                      o_inside_res,
    output logic                      o_truncated,

    // tolerance register
    input  logic                      i_cfg_wr_en,
    input  logic [TOL_W-1:0]          i_cfg_wr_data
);

    localparam int IDX_W = $clog2(MAX_VERTICES);
    localparam int CNT_W = $clog2(MAX_VERTICES + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_VERTICES);

    // control state
    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_count;
    logic             r_ovf;
    logic [TOL_W-1:0] r_tol;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic             r_wrap;
    logic             r_last;
    logic             r_parity;
    t_mul_step        r_step;
    t_mul_step        r_pstep;
    logic             r_pvalid;

    // vertex store, x in the upper half
    logic [2*COORD_W-1:0] mem [MAX_VERTICES];
    logic [2*COORD_W-1:0] r_rd_data;

    // query point, tolerance applied
    logic signed [COORD_W-1:0] r_qy;
    logic signed [EXT_W-1:0]   r_xm, r_xp, r_ym, r_yp;

    // edge endpoints
    logic signed [COORD_W-1:0] r_first_x, r_first_y;
    logic signed [COORD_W-1:0] r_prev_x, r_prev_y;
    logic signed [COORD_W-1:0] r_ax, r_ay, r_bx, r_by;

    // edge differences and extents
    logic signed [DIFF_W-1:0]  r_dx, r_dy, r_da;
    logic signed [EXT_W-1:0]   r_dc;
    logic signed [COORD_W-1:0] r_minx, r_maxx, r_miny, r_maxy;

    // multiply operands and accumulator
    logic signed [DIFF_W-1:0] r_mdx, r_mdy;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;

    logic                      w_accept;
    logic signed [COORD_W-1:0] w_cur_x, w_cur_y;
    logic                      w_idx_last;
    logic                      w_first_load;
    logic signed [EXT_W-1:0]   w_tol_s;
    logic signed [EXT_W-1:0]   w_px_s, w_py_s;
    logic                      w_dy_neg;
    logic signed [DIFF_W-1:0]  w_dy_abs, w_dx_adj;
    logic                      w_skip, w_in_span, w_left, w_mid;
    logic signed [EXT_W-1:0]   w_mdx_ext, w_mdy_ext;
    logic signed [MUL_A_W-1:0] w_mul_a;
    logic signed [MUL_B_W-1:0] w_mul_b;
    logic signed [PROD_W-1:0]  w_prod;
    logic                      w_term_hi, w_term_sub;
    logic signed [ACC_W-1:0]   w_term;
    logic signed [ACC_W-1:0]   w_acc_sum;
    logic                      w_cross;

    assign w_accept = i_valid && !o_stall;

    // current vertex: memory data, or the first vertex when closing the ring
    assign w_cur_x = r_wrap ? r_first_x : $signed(r_rd_data[2*COORD_W-1:COORD_W]);
    assign w_cur_y = r_wrap ? r_first_y : $signed(r_rd_data[COORD_W-1:0]);
    assign w_idx_last   = (CNT_W'(r_idx) + CNT_W'(1)) == r_count;
    assign w_first_load = (r_idx == '0) && !r_wrap;

    // tolerance shifted query bounds
    assign w_tol_s = $signed({{(EXT_W-TOL_W){1'b0}}, r_tol});
    assign w_px_s  = EXT_W'(i_px);
    assign w_py_s  = EXT_W'(i_py);

    // edge classification
    assign w_dy_neg  = r_dy[DIFF_W-1];
    assign w_dy_abs  = w_dy_neg ? -r_dy : r_dy;
    assign w_dx_adj  = w_dy_neg ? -r_dx : r_dx;
    assign w_skip    = $unsigned(w_dy_abs) <= {{(DIFF_W-TOL_W){1'b0}}, r_tol};
    assign w_in_span = (r_ym <= EXT_W'(r_maxy)) && (r_yp > EXT_W'(r_miny));
    assign w_left    = r_xm <= EXT_W'(r_minx);
    assign w_mid     = (r_xp > EXT_W'(r_minx)) && (r_xm < EXT_W'(r_maxx)) && w_in_span;

    // shared multiplier operand select
    assign w_mdx_ext = EXT_W'(r_mdx);
    assign w_mdy_ext = EXT_W'(r_mdy);

    always_comb begin
        w_mul_a = MUL_A_W'(r_da);
        w_mul_b = $signed({1'b0, w_mdx_ext[HALF_W-1:0]});
        case (r_step)
            MS_DX_LO: begin
                w_mul_a = MUL_A_W'(r_da);
                w_mul_b = $signed({1'b0, w_mdx_ext[HALF_W-1:0]});
            end
            MS_DX_HI: begin
                w_mul_a = MUL_A_W'(r_da);
                w_mul_b = MUL_B_W'($signed(w_mdx_ext[EXT_W-1:HALF_W]));
            end
            MS_DY_LO: begin
                w_mul_a = MUL_A_W'(r_dc);
                w_mul_b = $signed({1'b0, w_mdy_ext[HALF_W-1:0]});
            end
            MS_DY_HI: begin
                w_mul_a = MUL_A_W'(r_dc);
                w_mul_b = MUL_B_W'($signed(w_mdy_ext[EXT_W-1:HALF_W]));
            end
            default: begin
                w_mul_a = MUL_A_W'(r_da);
                w_mul_b = $signed({1'b0, w_mdx_ext[HALF_W-1:0]});
            end
        endcase
    end

    assign w_prod = PROD_W'(w_mul_a * w_mul_b);

    // accumulate (y-ay)*dx - (x-tol-ax)*dy from registered partial products
    assign w_term_hi  = (r_pstep == MS_DX_HI) || (r_pstep == MS_DY_HI);
    assign w_term_sub = (r_pstep == MS_DY_LO) || (r_pstep == MS_DY_HI);
    assign w_term     = w_term_hi ? (ACC_W'(r_prod) <<< HALF_W) : ACC_W'(r_prod);
    assign w_acc_sum  = w_term_sub ? (r_acc - w_term) : (r_acc + w_term);
    assign w_cross    = !w_acc_sum[ACC_W-1] && (w_acc_sum != '0);

    // next state and handshake outputs
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        case (r_state)
            S_IDLE: begin
                if (w_accept && i_func == FUNC_TEST) begin
                    n_idx   = '0;
                    n_state = (r_count == '0) ? S_OUT : S_LOAD;
                end
            end
            S_LOAD: begin
                if (!r_wrap && !w_idx_last) begin
                    n_idx = r_idx + 1'b1;
                end
                n_state = w_first_load ? S_LOAD : S_EDGE1;
            end
            S_EDGE1: n_state = S_EDGE2;
            S_EDGE2: begin
                if (!w_skip && !w_left && w_mid) begin
                    n_state = S_MUL;
                end else begin
                    n_state = r_last ? S_OUT : S_LOAD;
                end
            end
            S_MUL: begin
                if (r_step == MS_DY_HI) begin
                    n_state = S_ACC;
                end
            end
            S_ACC:   n_state = r_last ? S_OUT : S_LOAD;
            S_OUT: begin
                if (!i_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_stall      = (r_state != S_IDLE);
    assign o_valid      = (r_state == S_OUT);
    assign o_inside_res = r_parity;
    assign o_truncated  = r_ovf;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovf    <= 1'b0;
            r_tol    <= '0;
            r_idx    <= '0;
            r_wrap   <= 1'b0;
            r_last   <= 1'b0;
            r_parity <= 1'b0;
            r_step   <= MS_DX_LO;
            r_pstep  <= MS_DX_LO;
            r_pvalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            if (i_cfg_wr_en) begin
                r_tol <= i_cfg_wr_data;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        case (i_func)
                            FUNC_CLEAR: begin
                                r_count <= '0;
                                r_ovf   <= 1'b0;
                            end
                            FUNC_APPEND: begin
                                if (r_count < CNT_MAX) begin
                                    r_count <= r_count + 1'b1;
                                end else begin
                                    r_ovf <= 1'b1;
                                end
                            end
                            FUNC_TEST: begin
                                r_parity <= 1'b0;
                                r_wrap   <= 1'b0;
                            end
                            default: ;
                        endcase
                    end
                end
                S_LOAD: begin
                    r_last <= r_wrap;
                    if (!r_wrap && w_idx_last) begin
                        r_wrap <= 1'b1;
                    end
                end
                S_EDGE2: begin
                    r_step   <= MS_DX_LO;
                    r_pvalid <= 1'b0;
                    if (!w_skip && w_left && w_in_span) begin
                        r_parity <= ~r_parity;
                    end
                end
                S_MUL: begin
                    r_step   <= t_mul_step'(r_step + 2'd1);
                    r_pstep  <= r_step;
                    r_pvalid <= 1'b1;
                end
                S_ACC: begin
                    if (w_cross) begin
                        r_parity <= ~r_parity;
                    end
                end
                default: ;
            endcase
        end
    end

    // vertex store write and registered read
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && w_accept && i_func == FUNC_APPEND && r_count < CNT_MAX) begin
            mem[r_count[IDX_W-1:0]] <= {i_px, i_py};
        end
        r_rd_data <= mem[n_idx];
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_qy <= i_py;
                r_xm <= w_px_s - w_tol_s;
                r_xp <= w_px_s + w_tol_s;
                r_ym <= w_py_s - w_tol_s;
                r_yp <= w_py_s + w_tol_s;
            end
            S_LOAD: begin
                if (w_first_load) begin
                    r_first_x <= w_cur_x;
                    r_first_y <= w_cur_y;
                end
                r_prev_x <= w_cur_x;
                r_prev_y <= w_cur_y;
                r_ax     <= r_prev_x;
                r_ay     <= r_prev_y;
                r_bx     <= w_cur_x;
                r_by     <= w_cur_y;
            end
            S_EDGE1: begin
                r_dx   <= DIFF_W'(r_bx) - DIFF_W'(r_ax);
                r_dy   <= DIFF_W'(r_by) - DIFF_W'(r_ay);
                r_da   <= DIFF_W'(r_qy) - DIFF_W'(r_ay);
                r_dc   <= r_xm - EXT_W'(r_ax);
                r_minx <= (r_ax < r_bx) ? r_ax : r_bx;
                r_maxx <= (r_ax > r_bx) ? r_ax : r_bx;
                r_miny <= (r_ay < r_by) ? r_ay : r_by;
                r_maxy <= (r_ay > r_by) ? r_ay : r_by;
            end
            S_EDGE2: begin
                r_mdx <= w_dx_adj;
                r_mdy <= w_dy_abs;
                r_acc <= '0;
            end
            S_MUL: begin
                r_prod <= w_prod;
                if (r_pvalid) begin
                    r_acc <= w_acc_sum;
                end
            end
            default: ;
        endcase
    end

    // the walk never reads past the last stored vertex
    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD || r_state == S_EDGE1 || r_state == S_EDGE2)
            |-> (CNT_W'(r_idx) < r_count))
        else $error("vertex index beyond stored count");

    // the vertex count never exceeds capacity
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_MAX)
        else $error("vertex count above capacity");

    // a test of an empty polygon answers outside at once
    a_empty_outside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_func == FUNC_TEST && r_count == '0)
            |=> (o_valid && !o_inside_res))
        else $error("empty polygon did not report outside");

    // an append to a full store raises the truncated flag
    a_full_sets_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_func == FUNC_APPEND && r_count == CNT_MAX) |=> r_ovf)
        else $error("dropped vertex did not set truncated");

    // the multiply sequence is entered only from edge classification
    a_mul_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL && $past(r_state) != S_MUL) |-> ($past(r_state) == S_EDGE2))
        else $error("multiply sequence entered out of order");

endmodule

[verif/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top - self-checking bench for the point-in-polygon ray-cast tester
// Builds polygons through clear and append requests, fires query points at
// them and checks every inside/truncated verdict against an even-odd
// predictor kept inside the bench, across tolerance settings, random idling
// on both channels, a long result hold-off and store overflow.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top
    import pip_pkg::*;
();

    localparam int          MAX_VERTS       = 64;
    localparam int          RANDOM_REQUESTS = 1690;
    localparam int          PHASE_REQUESTS  = 230;
    localparam int          QUIET_LIMIT     = 20000;
    localparam int          SETTLE_CYCLES   = 8;
    localparam int          TAIL_CYCLES     = 50;
    localparam int          HOLD_OFF_CYCLES = 1500;
    localparam logic [1:0]  FUNC_UNUSED     = 2'd3;

    typedef struct packed {
        logic in_poly;
        logic truncated;
    } t_verdict;

    // dut signals, inputs known from time zero
    logic                      i_clk         = 1'b0;
    logic                      i_rst_n       = 1'b0;
    logic                      i_valid       = 1'b0;
    logic                      o_stall;
    logic [1:0]                i_func        = FUNC_CLEAR;
    logic signed [COORD_W-1:0] i_px          = '0;
    logic signed [COORD_W-1:0] i_py          = '0;
    logic                      o_valid;
    logic                      i_stall       = 1'b0;
    logic                      o_inside_res;
    logic                      o_truncated;
    logic                      i_cfg_wr_en   = 1'b0;
    logic [TOL_W-1:0]          i_cfg_wr_data = '0;

    // polygon as the bench sees it
    int       poly_x [MAX_VERTS];
    int       poly_y [MAX_VERTS];
    int       poly_len       = 0;
    logic     poly_truncated = 1'b0;
    int       tolerance_q    = 0;

    t_verdict pending_verdicts [$];
    int       error_count    = 0;
    int       requests_sent  = 0;

    // idling knobs and the receiver hold-off request
    int       send_idle_pct  = 0;
    int       recv_stall_pct = 0;
    int       hold_request   = 0;
    int       hold_left      = 0;

    point_in_polygon_ray_cast #(
        .MAX_VERTICES (MAX_VERTS)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_func        (i_func),
        .i_px          (i_px),
        .i_py          (i_py),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_inside_res  (o_inside_res),
        .o_truncated   (o_truncated),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    // clock
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // even-odd crossing count over every closed edge of the stored polygon
    function automatic logic ray_cast_parity(longint qx, longint qy);
        logic                parity;
        logic                in_span;
        longint              ax, ay, bx, by, minx, maxx, miny, maxy, dx, dy, tol;
        logic signed [127:0] rise, run, gap, climb;
        int                  i, j;
        parity = 1'b0;
        tol    = longint'(tolerance_q);
        for (i = 0; i < poly_len; i++) begin
            j    = (i + 1 == poly_len) ? 0 : i + 1;
            ax   = poly_x[i];
            ay   = poly_y[i];
            bx   = poly_x[j];
            by   = poly_y[j];
            minx = (ax < bx) ? ax : bx;
            maxx = (ax > bx) ? ax : bx;
            miny = (ay < by) ? ay : by;
            maxy = (ay > by) ? ay : by;
            // flat edges never cross the ray
            if (maxy - miny > tol) begin
                in_span = (qy <= maxy + tol) && (qy > miny - tol);
                if (qx <= minx + tol) begin
                    if (in_span) parity = ~parity;
                end else if (minx - tol < qx && qx < maxx + tol && in_span) begin
                    dx = bx - ax;
                    dy = by - ay;
                    if (dy < 0) begin
                        dx = -dx;
                        dy = -dy;
                    end
                    // crossing x right of the point, cross-multiplied
                    rise  = qy - ay;
                    run   = dx;
                    gap   = qx - tol - ax;
                    climb = dy;
                    if (rise * run > gap * climb) parity = ~parity;
                end
            end
        end
        return parity;
    endfunction

    // update the polygon copy for one accepted transaction
    function automatic void apply_request(logic [1:0] func, logic [31:0] x, logic [31:0] y);
        t_verdict v;
        case (func)
            FUNC_CLEAR: begin
                poly_len       = 0;
                poly_truncated = 1'b0;
            end
            FUNC_APPEND: begin
                if (poly_len < MAX_VERTS) begin
                    poly_x[poly_len] = $signed(x);
                    poly_y[poly_len] = $signed(y);
                    poly_len++;
                end else begin
                    poly_truncated = 1'b1;
                end
            end
            FUNC_TEST: begin
                v.in_poly   = ray_cast_parity($signed(x), $signed(y));
                v.truncated = poly_truncated;
                pending_verdicts.push_back(v);
            end
            default: ;
        endcase
    endfunction

    // offer one transaction, starting and ending at a falling edge
    task automatic issue_request(input logic [1:0] func, input logic [31:0] x,
                                 input logic [31:0] y);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_func  <= func;
        i_px    <= x;
        i_py    <= y;
        do begin
            @(posedge i_clk);
        end while (o_stall);
        apply_request(func, x, y);
        if (func != FUNC_UNUSED) requests_sent++;
        @(negedge i_clk);
    endtask

    // sender pauses until every verdict is back and the block has gone quiet
    task automatic settle_idle();
        i_valid <= 1'b0;
        while (pending_verdicts.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_tolerance(input logic [TOL_W-1:0] value);
        settle_idle();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        tolerance_q    = value;
    endtask

    task automatic set_idle_mode(input int mode);
        case (mode)
            0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1:       begin send_idle_pct = 82; recv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct = 82; end
            default: begin send_idle_pct = 14; recv_stall_pct = 14; end
        endcase
    endtask

    function automatic int near(int centre, int reach);
        return centre + int'($urandom_range(2 * reach)) - reach;
    endfunction

    // empty polygon, ignored func code, clear with extreme payloads
    task automatic test_empty_polygon();
        set_idle_mode(0);
        issue_request(FUNC_TEST, 32'h0000_0000, 32'h0000_0000);
        issue_request(FUNC_UNUSED, 32'hFFFF_FFFF, 32'h8000_0000);
        issue_request(FUNC_CLEAR, 32'h7FFF_FFFF, 32'h0000_0001);
        issue_request(FUNC_TEST, 32'h8000_0000, 32'h7FFF_FFFF);
    endtask

    // square with vertical edges, full-range triangle, one and two vertices
    task automatic test_directed_shapes();
        issue_request(FUNC_CLEAR, 32'h0, 32'h0);
        issue_request(FUNC_APPEND, 32'h0000_0000, 32'h0000_0000);
        issue_request(FUNC_APPEND, 32'h0004_0000, 32'h0000_0000);
        issue_request(FUNC_APPEND, 32'h0004_0000, 32'h0004_0000);
        issue_request(FUNC_APPEND, 32'h0000_0000, 32'h0004_0000);
        issue_request(FUNC_TEST, 32'h0002_0000, 32'h0002_0000);
        issue_request(FUNC_TEST, 32'h0005_0000, 32'h0002_0000);
        issue_request(FUNC_TEST, 32'h0000_0000, 32'h0000_0000);
        issue_request(FUNC_TEST, 32'hFFFF_0000, 32'h0002_0000);
        issue_request(FUNC_CLEAR, 32'h0, 32'h0);
        issue_request(FUNC_APPEND, 32'h8000_0000, 32'h8000_0000);
        issue_request(FUNC_APPEND, 32'h7FFF_FFFF, 32'h8000_0000);
        issue_request(FUNC_APPEND, 32'h0000_0000, 32'h7FFF_FFFF);
        issue_request(FUNC_TEST, 32'h0000_0000, 32'h0000_0000);
        issue_request(FUNC_TEST, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        issue_request(FUNC_TEST, 32'h8000_0000, 32'h8000_0001);
        issue_request(FUNC_CLEAR, 32'h0, 32'h0);
        issue_request(FUNC_APPEND, 32'h0001_0000, 32'h0001_0000);
        issue_request(FUNC_TEST, 32'h0000_0000, 32'h0001_0000);
        issue_request(FUNC_APPEND, 32'h0001_0000, 32'h0003_0000);
        issue_request(FUNC_TEST, 32'h0000_0000, 32'h0002_0000);
    endtask

    // fill past capacity, then check that clear drops the truncated flag
    task automatic test_store_overflow();
        int k;
        issue_request(FUNC_CLEAR, 32'h0, 32'h0);
        for (k = 0; k < MAX_VERTS + 3; k++)
            issue_request(FUNC_APPEND, near(0, 1 << 16), near(0, 1 << 16));
        repeat (3) issue_request(FUNC_TEST, near(0, 1 << 16), near(0, 1 << 16));
        issue_request(FUNC_CLEAR, 32'h0, 32'h0);
        issue_request(FUNC_APPEND, 32'h0000_0000, 32'h0000_0000);
        issue_request(FUNC_APPEND, 32'h0002_0000, 32'h0000_0000);
        issue_request(FUNC_APPEND, 32'h0000_0000, 32'h0002_0000);
        issue_request(FUNC_TEST, 32'h0000_4000, 32'h0000_4000);
    endtask

    // tolerance at its extremes against a triangle with a sloped edge
    task automatic test_tolerance_extremes();
        logic [TOL_W-1:0] tol_set [4] = '{16'hFFFF, 16'h0001, 16'h8000, 16'h0000};
        int               t;
        for (t = 0; t < 4; t++) begin
            write_tolerance(tol_set[t]);
            issue_request(FUNC_CLEAR, 32'h0, 32'h0);
            issue_request(FUNC_APPEND, 32'h0000_0000, 32'h0000_0000);
            issue_request(FUNC_APPEND, 32'h0002_0000, 32'h0000_0000);
            issue_request(FUNC_APPEND, 32'h0000_0000, 32'h0001_8000);
            issue_request(FUNC_TEST, 32'h0000_8000, 32'h0000_8000);
            issue_request(FUNC_TEST, 32'h0001_0000, 32'h0000_C000);
            issue_request(FUNC_TEST, 32'h0001_0001, 32'h0000_C000);
            issue_request(FUNC_TEST, 32'h0000_FFFF, 32'h0000_C000);
            issue_request(FUNC_TEST, 32'hFFFF_FFFF, 32'h0000_0100);
            issue_request(FUNC_TEST, 32'h0002_0000, 32'h0000_0000);
        end
    endtask

    // long result hold-off while queries keep coming, then a full drain
    task automatic test_backpressure();
        set_idle_mode(0);
        issue_request(FUNC_CLEAR, 32'h0, 32'h0);
        issue_request(FUNC_APPEND, 32'h0000_0000, 32'h0000_0000);
        issue_request(FUNC_APPEND, 32'h0004_0000, 32'h0001_0000);
        issue_request(FUNC_APPEND, 32'h0003_0000, 32'h0005_0000);
        issue_request(FUNC_APPEND, 32'hFFFF_0000, 32'h0003_0000);
        hold_request = HOLD_OFF_CYCLES;
        repeat (12) issue_request(FUNC_TEST, near(1 << 17, 1 << 18), near(1 << 17, 1 << 18));
        settle_idle();
    endtask

    // one random polygon: optional clear, vertices, then a handful of queries
    task automatic run_random_polygon();
        int          verts, queries, span, cx, cy, k, r, pick;
        bit          wide;
        int          xs [$];
        int          ys [$];
        logic [31:0] qx, qy;
        r = $urandom_range(99);
        if (r < 4)       verts = $urandom_range(2);
        else if (r < 94) verts = $urandom_range(10, 3);
        else             verts = $urandom_range(70, 60);
        wide = ($urandom_range(9) == 0);
        case ($urandom_range(3))
            0:       span = 8;
            1:       span = 1 << 12;
            2:       span = 1 << 18;
            default: span = 1 << 20;
        endcase
        cx = $signed($urandom) >>> 1;
        cy = $signed($urandom) >>> 1;
        // noise: stray unused codes, or keep building on the old polygon
        if ($urandom_range(19) == 0) issue_request(FUNC_UNUSED, $urandom, $urandom);
        if ($urandom_range(9) != 0) issue_request(FUNC_CLEAR, $urandom, $urandom);
        for (k = 0; k < verts; k++) begin
            if (wide) begin
                xs.push_back($urandom);
                ys.push_back($urandom);
            end else begin
                xs.push_back(near(cx, span));
                ys.push_back(near(cy, span));
            end
            issue_request(FUNC_APPEND, xs[k], ys[k]);
            if ($urandom_range(19) == 0)
                issue_request(FUNC_TEST, near(cx, span), near(cy, span));
        end
        queries = (verts > MAX_VERTS / 2) ? $urandom_range(4, 1) : $urandom_range(8, 2);
        repeat (queries) begin
            pick = $urandom_range(9);
            if (xs.size() == 0) pick = 8;
            k = (xs.size() != 0) ? $urandom_range(xs.size() - 1) : 0;
            case (pick)
                4: begin qx = xs[k];                  qy = ys[k];                 end
                5: begin qx = near(cx, span);         qy = ys[k];                 end
                6: begin qx = near(xs[k], 70000);     qy = near(ys[k], 4);        end
                7: begin qx = xs[k];                  qy = near(cy, span);        end
                8: begin qx = $urandom;               qy = $urandom;              end
                9: begin qx = near(xs[k], 8);         qy = ys[k] + tolerance_q;   end
                default: begin
                    qx = wide ? $urandom : near(cx, span + span / 2);
                    qy = wide ? $urandom : near(cy, span + span / 2);
                end
            endcase
            issue_request(FUNC_TEST, qx, qy);
        end
    endtask

    // random phases, each with its own tolerance and idling pattern
    task automatic test_random_polygons();
        int phase, phase_end, target;
        phase  = 0;
        target = requests_sent + RANDOM_REQUESTS;
        while (requests_sent < target) begin
            case ((phase + phase / 4) % 4)
                0:       write_tolerance(16'h0000);
                1:       write_tolerance(16'hFFFF);
                2:       write_tolerance(TOL_W'($urandom_range(16, 1)));
                default: write_tolerance(TOL_W'($urandom_range(16'hFFFF)));
            endcase
            set_idle_mode(phase % 4);
            phase_end = requests_sent + PHASE_REQUESTS;
            while (requests_sent < phase_end && requests_sent < target)
                run_random_polygon();
            phase++;
        end
    endtask

    // receiver: random stalls, or a counted hold-off when one is requested
    always @(negedge i_clk) begin
        if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            i_stall <= 1'b1;
            hold_left--;
        end else begin
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // compare each result transaction with the oldest expected verdict
    always @(posedge i_clk) begin : result_check
        t_verdict want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_verdicts.size() == 0) begin
                $error("unexpected result: inside_res=%0b truncated=%0b",
                       o_inside_res, o_truncated);
                error_count++;
            end else begin
                want = pending_verdicts.pop_front();
                if (o_inside_res !== want.in_poly) begin
                    $error("inside_res: expected %0b, got %0b", want.in_poly, o_inside_res);
                    error_count++;
                end
                if (o_truncated !== want.truncated) begin
                    $error("truncated: expected %0b, got %0b", want.truncated, o_truncated);
                    error_count++;
                end
            end
        end
    end

    // watchdog on cycles with no transaction on either channel
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("tb_top: done, errors");
        $finish;
    end

    // reset, test sequence, final verdict
    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_polygon();
        test_directed_shapes();
        test_store_overflow();
        test_tolerance_extremes();
        test_backpressure();
        test_random_polygons();
        settle_idle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0 && pending_verdicts.size() == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
